// ===== src/vbd_pkg.sv =====
// vbd_pkg: shared types and constants for the voxel burial depth query block
// no dependencies; imported by every module under src

package vbd_pkg;

  // default grid bounds and search radius limit
  localparam int unsigned GridXMaxDef  = 64;
  localparam int unsigned GridYMaxDef  = 64;
  localparam int unsigned GridZMaxDef  = 64;
  localparam int unsigned RadiusMaxDef = 15;

  // field widths fixed by the stream format
  localparam int unsigned PosW   = 6;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned DepthW = 5;
  localparam int unsigned LimW   = 4;
  localparam int unsigned CoordW = 9;
  localparam int unsigned RegIdxW = 3;

  // request kinds on the input stream
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_SIZE_X        = 3'd0,
    REG_SIZE_Y        = 3'd1,
    REG_SIZE_Z        = 3'd2,
    REG_MAX_DEPTH     = 3'd3,
    REG_ALLOWED_DEPTH = 3'd4
  } reg_idx_e;

  // configuration handed to the sequencer
  typedef struct packed {
    logic [SizeW-1:0] size_x;
    logic [SizeW-1:0] size_y;
    logic [SizeW-1:0] size_z;
    logic [LimW-1:0]  max_depth;
    logic [LimW-1:0]  allowed_depth;
  } cfg_t;

endpackage

// ===== src/vbd_grid_mem.sv =====
// vbd_grid_mem: occupancy grid storage, one x row per word, registered read
// depends on vbd_pkg for the default row width

module vbd_grid_mem
  import vbd_pkg::*;
#(
  parameter int unsigned ROW_W = GridXMaxDef,
  parameter int unsigned AW    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [ROW_W-1:0] wdata_i,
  output logic [ROW_W-1:0] rdata_o
);

  logic [ROW_W-1:0] mem_q [2**AW];
  logic [ROW_W-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vbd_seq.sv =====
// vbd_seq: request sequencer; clears the grid, does read-modify-write updates
// and walks the cube shells of a query one row per cycle; depends on vbd_pkg

module vbd_seq
  import vbd_pkg::*;
#(
  parameter int unsigned GRID_X_MAX = GridXMaxDef,
  parameter int unsigned GRID_Y_MAX = GridYMaxDef,
  parameter int unsigned GRID_Z_MAX = GridZMaxDef,
  parameter int unsigned RADIUS_MAX = RadiusMaxDef,
  localparam int unsigned XW = $clog2(GRID_X_MAX),
  localparam int unsigned YW = $clog2(GRID_Y_MAX),
  localparam int unsigned ZW = $clog2(GRID_Z_MAX),
  localparam int unsigned AW = YW + ZW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_kind_i,
  input  logic [PosW-1:0]       in_pos_x_i,
  input  logic [PosW-1:0]       in_pos_y_i,
  input  logic [PosW-1:0]       in_pos_z_i,
  input  logic                  in_occupied_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DepthW-1:0]     out_depth_o,
  output logic                  out_too_deep_o,
  output logic                  out_off_grid_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_addr_o,
  output logic [GRID_X_MAX-1:0] mem_wdata_o,
  input  logic [GRID_X_MAX-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_RUN,
    ST_DONE
  } state_e;

  localparam logic [CoordW-1:0] GX = CoordW'(GRID_X_MAX);
  localparam logic [CoordW-1:0] GY = CoordW'(GRID_Y_MAX);
  localparam logic [CoordW-1:0] GZ = CoordW'(GRID_Z_MAX);
  localparam logic [DepthW-1:0] RMAX =
    (RADIUS_MAX > 15) ? DepthW'(15) : DepthW'(RADIUS_MAX);

  state_e                state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [CoordW-1:0]     px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic                  occ_q, occ_d;
  logic [DepthW-1:0]     r_q, r_d;
  logic signed [DepthW:0] b_q, b_d, c_q, c_d;
  logic                  vld_q, vld_d;
  logic [GRID_X_MAX-1:0] mask_q, mask_d;
  logic [DepthW-1:0]     rr_q, rr_d;
  logic [DepthW-1:0]     res_q, res_d;
  logic                  off_q, off_d;
  logic                  ovld_q, ovld_d;
  logic [DepthW-1:0]     odepth_q, odepth_d;
  logic                  otd_q, otd_d;
  logic                  ooff_q, ooff_d;

  logic [CoordW-1:0]     sx, sy, sz, ix, iy, iz, ty, tz, lo, hi;
  logic [DepthW-1:0]     lim;
  logic signed [DepthW:0] rs;
  logic                  in_grid, shell_start, offg, full, found;
  logic [GRID_X_MAX-1:0] mask_full, mask_sparse, wrow;

  // sizes in use and search limit
  always_comb begin
    sx  = (CoordW'(cfg_i.size_x) > GX) ? GX : CoordW'(cfg_i.size_x);
    sy  = (CoordW'(cfg_i.size_y) > GY) ? GY : CoordW'(cfg_i.size_y);
    sz  = (CoordW'(cfg_i.size_z) > GZ) ? GZ : CoordW'(cfg_i.size_z);
    lim = (DepthW'(cfg_i.max_depth) > RMAX) ? RMAX : DepthW'(cfg_i.max_depth);
    ix  = CoordW'(in_pos_x_i);
    iy  = CoordW'(in_pos_y_i);
    iz  = CoordW'(in_pos_z_i);
    in_grid = (ix < sx) && (iy < sy) && (iz < sz);
  end

  // shell walk geometry for the row about to be read
  always_comb begin
    rs          = $signed({1'b0, r_q});
    shell_start = (b_q == -rs) && (c_q == -rs);
    offg = (px_q < CoordW'(r_q)) || (py_q < CoordW'(r_q)) || (pz_q < CoordW'(r_q)) ||
           (px_q + CoordW'(r_q) >= sx) || (py_q + CoordW'(r_q) >= sy) ||
           (pz_q + CoordW'(r_q) >= sz);
    ty   = py_q + {{(CoordW-DepthW-1){b_q[DepthW]}}, b_q};
    tz   = pz_q + {{(CoordW-DepthW-1){c_q[DepthW]}}, c_q};
    full = (b_q == rs) || (b_q == -rs) || (c_q == rs) || (c_q == -rs);
    lo   = px_q - CoordW'(r_q);
    hi   = px_q + CoordW'(r_q);
    mask_full   = ~({GRID_X_MAX{1'b1}} << (hi + CoordW'(1))) &
                  ({GRID_X_MAX{1'b1}} << lo);
    mask_sparse = (GRID_X_MAX'(1) << lo) | (GRID_X_MAX'(1) << hi);
    found = vld_q && (|(~mem_rdata_i & mask_q));
    wrow  = mem_rdata_i;
    wrow[px_q[XW-1:0]] = occ_q;
  end

  // next state
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    px_d     = px_q;
    py_d     = py_q;
    pz_d     = pz_q;
    occ_d    = occ_q;
    r_d      = r_q;
    b_d      = b_q;
    c_d      = c_q;
    vld_d    = 1'b0;
    mask_d   = mask_q;
    rr_d     = rr_q;
    res_d    = res_q;
    off_d    = off_q;
    ovld_d   = ovld_q && !out_ready_i;
    odepth_d = odepth_q;
    otd_d    = otd_q;
    ooff_d   = ooff_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = {iz[ZW-1:0], iy[YW-1:0]};
    mem_wdata_o = '0;

    unique case (state_q)
      // zero every row after reset
      ST_CLEAR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
        clr_d      = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      // take one request
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          px_d  = ix;
          py_d  = iy;
          pz_d  = iz;
          occ_d = in_occupied_i;
          r_d   = '0;
          b_d   = '0;
          c_d   = '0;
          if (in_kind_i == KIND_WRITE) begin
            if (in_grid) begin
              state_d = ST_WRITE;
            end
          end else if (in_grid) begin
            state_d = ST_RUN;
          end else begin
            res_d   = '0;
            off_d   = 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      // write back the modified row
      ST_WRITE: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = {pz_q[ZW-1:0], py_q[YW-1:0]};
        mem_wdata_o = wrow;
        state_d     = ST_IDLE;
      end
      // check the row read last cycle, issue the next one
      ST_RUN: begin
        mem_addr_o = {tz[ZW-1:0], ty[YW-1:0]};
        off_d      = 1'b0;
        if (found) begin
          res_d   = rr_q;
          state_d = ST_DONE;
        end else if (shell_start && ((r_q > lim) || offg)) begin
          res_d   = (r_q > lim) ? lim + DepthW'(1) : r_q;
          state_d = ST_DONE;
        end else begin
          vld_d  = 1'b1;
          rr_d   = r_q;
          mask_d = full ? mask_full : mask_sparse;
          if (b_q == rs) begin
            if (c_q == rs) begin
              r_d = r_q + DepthW'(1);
              b_d = -(rs + 2'sd1);
              c_d = -(rs + 2'sd1);
            end else begin
              b_d = -rs;
              c_d = c_q + 2'sd1;
            end
          end else begin
            b_d = b_q + 2'sd1;
          end
        end
      end
      // hand the result to the output register
      ST_DONE: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d   = 1'b1;
          odepth_d = res_q;
          otd_d    = !off_q && (res_q > DepthW'(cfg_i.allowed_depth));
          ooff_d   = off_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      px_q     <= '0;
      py_q     <= '0;
      pz_q     <= '0;
      occ_q    <= 1'b0;
      r_q      <= '0;
      b_q      <= '0;
      c_q      <= '0;
      vld_q    <= 1'b0;
      mask_q   <= '0;
      rr_q     <= '0;
      res_q    <= '0;
      off_q    <= 1'b0;
      ovld_q   <= 1'b0;
      odepth_q <= '0;
      otd_q    <= 1'b0;
      ooff_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      px_q     <= px_d;
      py_q     <= py_d;
      pz_q     <= pz_d;
      occ_q    <= occ_d;
      r_q      <= r_d;
      b_q      <= b_d;
      c_q      <= c_d;
      vld_q    <= vld_d;
      mask_q   <= mask_d;
      rr_q     <= rr_d;
      res_q    <= res_d;
      off_q    <= off_d;
      ovld_q   <= ovld_d;
      odepth_q <= odepth_d;
      otd_q    <= otd_d;
      ooff_q   <= ooff_d;
    end
  end

  assign out_valid_o    = ovld_q;
  assign out_depth_o    = odepth_q;
  assign out_too_deep_o = otd_q;
  assign out_off_grid_o = ooff_q;

  // a pending row check only follows a shell walk cycle
  a_vld_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> $past(state_q == ST_RUN))
    else $error("row check without a walk cycle");

  // an off-grid result never carries a depth
  a_off_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && ooff_q) |-> (odepth_q == '0 && !otd_q))
    else $error("off-grid result with depth");

  // depth never passes the search limit plus one
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> (odepth_q <= RMAX + DepthW'(1)))
    else $error("depth beyond search limit");

  // memory is written only while clearing or updating a row
  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == ST_CLEAR || state_q == ST_WRITE))
    else $error("unexpected grid write");

endmodule

// ===== src/voxel_burial_depth_query.sv =====
// voxel_burial_depth_query: top level; configuration registers, grid memory
// and request sequencer; depends on vbd_pkg, vbd_grid_mem and vbd_seq
//
// Usage:
//  - s_axis carries requests. tuser is the kind (0 write, 1 query);
//    tdata holds pos_x, pos_y, pos_z and occupied. A write sets or clears
//    one voxel and gives nothing back; a query gives one result on m_axis.
//  - m_axis tdata holds depth, too_deep and off_grid.
//  - cfg writes one register by index (size_x, size_y, size_z, max_depth,
//    allowed_depth), always ready; users use it while no request is open, unenforced.
//  - After reset a clearing pass zeroes all GRID_Y_MAX*GRID_Z_MAX rows (4096 by
//    default) of the grid memory, one row a cycle; s_axis is held off.
//  - One request at a time. A write reads the row and writes it back; an
//    off-grid write is dropped. A query reads the center row, then (2r+1)^2
//    rows for each shell radius r that is searched; the single read port of
//    the grid memory sets the pace. An off-grid query reads no rows.
//  - A result waits in the output register while m_axis stalls; the next
//    request is taken meanwhile and a further result waits for that slot.

module voxel_burial_depth_query
  import vbd_pkg::*;
#(
  parameter int unsigned GRID_X_MAX = GridXMaxDef,
  parameter int unsigned GRID_Y_MAX = GridYMaxDef,
  parameter int unsigned GRID_Z_MAX = GridZMaxDef,
  parameter int unsigned RADIUS_MAX = RadiusMaxDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // pos_x, pos_y, pos_z, occupied, zero fill
  input  logic               s_axis_tuser,   // kind
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // depth, too_deep, off_grid, zero fill
  // register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i
);

  localparam int unsigned YW = $clog2(GRID_Y_MAX);
  localparam int unsigned ZW = $clog2(GRID_Z_MAX);
  localparam int unsigned AW = YW + ZW;

  cfg_t                  cfg_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [GRID_X_MAX-1:0] mem_wdata, mem_rdata;
  logic [DepthW-1:0]     depth;
  logic                  too_deep, off_grid;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x        <= SizeW'(64);
      cfg_q.size_y        <= SizeW'(64);
      cfg_q.size_z        <= SizeW'(64);
      cfg_q.max_depth     <= LimW'(8);
      cfg_q.allowed_depth <= LimW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SIZE_X:        cfg_q.size_x        <= cfg_data_i;
        REG_SIZE_Y:        cfg_q.size_y        <= cfg_data_i;
        REG_SIZE_Z:        cfg_q.size_z        <= cfg_data_i;
        REG_MAX_DEPTH:     cfg_q.max_depth     <= cfg_data_i[LimW-1:0];
        REG_ALLOWED_DEPTH: cfg_q.allowed_depth <= cfg_data_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // occupancy grid
  vbd_grid_mem #(
    .ROW_W (GRID_X_MAX),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // request sequencer
  vbd_seq #(
    .GRID_X_MAX (GRID_X_MAX),
    .GRID_Y_MAX (GRID_Y_MAX),
    .GRID_Z_MAX (GRID_Z_MAX),
    .RADIUS_MAX (RADIUS_MAX)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_kind_i      (s_axis_tuser),
    .in_pos_x_i     (s_axis_tdata[5:0]),
    .in_pos_y_i     (s_axis_tdata[11:6]),
    .in_pos_z_i     (s_axis_tdata[17:12]),
    .in_occupied_i  (s_axis_tdata[18]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_depth_o    (depth),
    .out_too_deep_o (too_deep),
    .out_off_grid_o (off_grid),
    .mem_we_o       (mem_we),
    .mem_addr_o     (mem_addr),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata)
  );

  assign m_axis_tdata = {1'b0, off_grid, too_deep, depth};

endmodule

// ===== dv/testbench.sv =====
// testbench for voxel_burial_depth_query: streams voxel writes and depth queries,
// predicts every result in a scoreboard class; depends on vbd_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import vbd_pkg::*;

  // expected fields of one query result
  typedef struct {
    logic [DepthW-1:0] depth;
    logic              too_deep;
    logic              off_grid;
  } depth_result_t;

  // occupancy mirror, register copy and store of expected depth results
  class depth_scoreboard;
    bit            occ_mirror [GridXMaxDef*GridYMaxDef*GridZMaxDef];
    int unsigned   size_x, size_y, size_z, max_depth, allowed_depth;
    depth_result_t expected_depths[$];
    int            mismatches;

    function new();
      foreach (occ_mirror[i]) occ_mirror[i] = 1'b0;
      size_x = 64; size_y = 64; size_z = 64; max_depth = 8; allowed_depth = 1;
      mismatches = 0;
    endfunction

    function int voxel_addr(int x, int y, int z);
      return x + GridXMaxDef * (y + GridYMaxDef * z);
    endfunction

    function void note_register(reg_idx_e idx, int unsigned value);
      case (idx)
        REG_SIZE_X:        size_x = value & 7'h7f;
        REG_SIZE_Y:        size_y = value & 7'h7f;
        REG_SIZE_Z:        size_z = value & 7'h7f;
        REG_MAX_DEPTH:     max_depth = value & 4'hf;
        REG_ALLOWED_DEPTH: allowed_depth = value & 4'hf;
        default: ;
      endcase
    endfunction

    // chebyshev distance to the nearest free voxel, grid edge counts as free
    function int burial_depth(int px, int py, int pz, int sx, int sy, int sz);
      int lim;
      int gx, gy, gz;
      lim = (max_depth > RadiusMaxDef) ? RadiusMaxDef : max_depth;
      if (!occ_mirror[voxel_addr(px, py, pz)]) return 0;
      for (int r = 1; r <= lim; r++)
        for (int c = -r; c <= r; c++)
          for (int b = -r; b <= r; b++)
            for (int a = -r; a <= r; a++) begin
              if (a != r && a != -r && b != r && b != -r && c != r && c != -r) continue;
              gx = px + a; gy = py + b; gz = pz + c;
              if (gx < 0 || gy < 0 || gz < 0 || gx >= sx || gy >= sy || gz >= sz) return r;
              if (!occ_mirror[voxel_addr(gx, gy, gz)]) return r;
            end
      return lim + 1;
    endfunction

    // one accepted request: update the mirror or queue the expected result
    function void note_request(logic kind, int px, int py, int pz, logic occ);
      int sx, sy, sz, d;
      bit on_grid;
      depth_result_t res;
      sx = (size_x > GridXMaxDef) ? GridXMaxDef : size_x;
      sy = (size_y > GridYMaxDef) ? GridYMaxDef : size_y;
      sz = (size_z > GridZMaxDef) ? GridZMaxDef : size_z;
      on_grid = px < sx && py < sy && pz < sz;
      if (kind == KIND_WRITE) begin
        if (on_grid) occ_mirror[voxel_addr(px, py, pz)] = occ;
        return;
      end
      if (!on_grid) begin
        res.depth = '0; res.too_deep = 1'b0; res.off_grid = 1'b1;
      end else begin
        d = burial_depth(px, py, pz, sx, sy, sz);
        res.depth = d[DepthW-1:0];
        res.too_deep = d > allowed_depth;
        res.off_grid = 1'b0;
      end
      expected_depths.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [7:0] tdata);
      depth_result_t exp_res;
      if (expected_depths.size() == 0) begin
        report($sformatf("unexpected result %h", tdata));
        return;
      end
      exp_res = expected_depths.pop_front();
      if (tdata[4:0] !== exp_res.depth)
        report($sformatf("depth %0d, expected %0d", tdata[4:0], exp_res.depth));
      if (tdata[5] !== exp_res.too_deep)
        report($sformatf("too_deep %b, expected %b", tdata[5], exp_res.too_deep));
      if (tdata[6] !== exp_res.off_grid)
        report($sformatf("off_grid %b, expected %b", tdata[6], exp_res.off_grid));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [RegIdxW-1:0] cfg_index_i = '0;
  logic [SizeW-1:0]   cfg_data_i = '0;

  depth_scoreboard sb = new();
  int burst_left = 0;

  voxel_burial_depth_query dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall pattern: randomly chosen modes of always ready, random and long stalls
  int stall_mode = 0;
  int mode_left = 0;
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(5, 60);
    end
    mode_left--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // result checking
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  // one request, sender sometimes idles between bursts; called just after a falling edge
  task send_request(logic kind, int px, int py, int pz, logic occ);
    s_axis_tuser = kind;
    s_axis_tdata = {5'b0, occ, pz[5:0], py[5:0], px[5:0]};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(kind, px, py, pz, occ);
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end else burst_left--;
  endtask

  task write_register(reg_idx_e idx, int unsigned value);
    cfg_index_i = idx;
    cfg_data_i = value[SizeW-1:0];
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_register(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // block idle: all results back and a trailing write finished
  task wait_idle();
    s_axis_tvalid = 1'b0;
    while (sb.expected_depths.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task set_grid(int sx, int sy, int sz, int md, int ad);
    wait_idle();
    write_register(REG_SIZE_X, sx);
    write_register(REG_SIZE_Y, sy);
    write_register(REG_SIZE_Z, sz);
    write_register(REG_MAX_DEPTH, md);
    write_register(REG_ALLOWED_DEPTH, ad);
  endtask

  function int clip63(int v);
    return (v < 0) ? 0 : (v > 63) ? 63 : v;
  endfunction

  // a cluster around a center: 3x3x3 cube fill, a center query, then writes and
  // queries within 4 of it, plus some noise anywhere on the whole coordinate range
  task run_cluster_phase(int n_items);
    int cx, cy, cz, hw, sel;
    cx = $urandom_range(0, (sb.size_x > 0 && sb.size_x < 64) ? sb.size_x : 63);
    cy = $urandom_range(0, (sb.size_y > 0 && sb.size_y < 64) ? sb.size_y : 63);
    cz = $urandom_range(0, (sb.size_z > 0 && sb.size_z < 64) ? sb.size_z : 63);
    hw = 1;
    for (int z = -hw; z <= hw; z++)
      for (int y = -hw; y <= hw; y++)
        for (int x = -hw; x <= hw; x++)
          send_request(KIND_WRITE, clip63(cx + x), clip63(cy + y), clip63(cz + z), 1'b1);
    send_request(KIND_QUERY, cx, cy, cz, 1'b0);
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 1)
        send_request($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 63), $urandom_range(0, 1));
      else
        send_request((sel < 6) ? KIND_WRITE : KIND_QUERY,
                     clip63(cx + $urandom_range(0, 8) - 4), clip63(cy + $urandom_range(0, 8) - 4),
                     clip63(cz + $urandom_range(0, 8) - 4), ($urandom_range(0, 4) != 0));
    end
  endtask

  // stimulus
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: corners, edge, buried voxel, cleared voxel
    send_request(KIND_QUERY, 0, 0, 0, 1'b0);
    send_request(KIND_QUERY, 63, 63, 63, 1'b1);
    send_request(KIND_WRITE, 63, 63, 63, 1'b1);
    send_request(KIND_QUERY, 63, 63, 63, 1'b0);
    send_request(KIND_WRITE, 0, 0, 0, 1'b1);
    send_request(KIND_WRITE, 0, 0, 0, 1'b0);
    send_request(KIND_QUERY, 0, 0, 0, 1'b1);
    for (int i = 9; i <= 11; i++) begin
      send_request(KIND_WRITE, i, 10, 10, 1'b1);
      send_request(KIND_WRITE, 10, i, 10, 1'b1);
      send_request(KIND_WRITE, 10, 10, i, 1'b1);
    end
    send_request(KIND_QUERY, 10, 10, 10, 1'b0);
    send_request(KIND_QUERY, 11, 10, 10, 1'b0);
    send_request(KIND_WRITE, 42, 21, 63, 1'b1);
    send_request(KIND_QUERY, 42, 21, 63, 1'b0);

    // configured phases: extremes first, then random settings
    set_grid(8, 8, 8, 2, 1);       run_cluster_phase(40);
    set_grid(1, 1, 1, 0, 0);       run_cluster_phase(20);
    set_grid(0, 5, 5, 3, 2);       run_cluster_phase(20);
    set_grid(127, 100, 64, 15, 15); run_cluster_phase(50);
    set_grid(6, 9, 12, 1, 0);      run_cluster_phase(40);
    set_grid(64, 64, 64, 8, 3);    run_cluster_phase(40);
    repeat (3) begin
      set_grid($urandom_range(1, 127), $urandom_range(1, 127), $urandom_range(1, 127),
               $urandom_range(0, 15), $urandom_range(0, 15));
      run_cluster_phase(40);
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_depths.size() == 0)
      $display("voxel_burial_depth_query test passed");
    else
      $display("voxel_burial_depth_query test failed");
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("voxel_burial_depth_query test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/vbd_pkg.sv
src/vbd_grid_mem.sv
src/vbd_seq.sv
src/voxel_burial_depth_query.sv
dv/testbench.sv
